// ===== src/tpbc_pkg.sv =====
package tpbc_pkg;

   // Fixed field widths
   localparam int ADDR_W     = 64;
   localparam int SIZE_W     = 52;
   localparam int EBASE_W    = 52;
   localparam int SITE_W     = 64;
   localparam int ETAG_W     = 12;
   localparam int PROBE_W    = 12;
   localparam int HW_W       = 8;
   localparam int MBS_W      = 12;
   localparam int CSR_DATA_W = 12;

   // Configuration reset values
   localparam logic [HW_W-1:0]  HW_RESET  = 8'd16;
   localparam logic [MBS_W-1:0] MBS_RESET = 12'd24;

   // Stack pointer marker in the top address bits
   localparam int          STACK_LSB  = 48;
   localparam logic [15:0] STACK_MARK = 16'hffff;

   typedef enum logic [1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_FREE   = 2'd1,
      MODE_ACCESS = 2'd2,
      MODE_PROBE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_UNTRACKED    = 3'd1,
      STATUS_HEADER       = 3'd2,
      STATUS_OUT_OF_BOUND = 3'd3,
      STATUS_USE_AFTER    = 3'd4,
      STATUS_TAG_MISMATCH = 3'd5,
      STATUS_TABLE_FULL   = 3'd6,
      STATUS_DOUBLE_FREE  = 3'd7
   } status_type;

   typedef enum logic {
      CSR_HEADER_WINDOW  = 1'b0,
      CSR_MIN_BLOCK_SIZE = 1'b1
   } csr_index_type;

   // Table port strobes
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tbl_ctrl_type;

endpackage

// ===== src/tpbc_if.sv =====
interface tpbc_req_if;
   import tpbc_pkg::*;

   logic                 valid;
   logic                 ready;
   mode_type             mode;
   logic [ADDR_W-1:0]    address;
   logic [ADDR_W-1:0]    base_ptr;
   logic [SIZE_W-1:0]    alloc_size;
   logic [SITE_W-1:0]    call_site;
   logic [PROBE_W-1:0]   probe_index;

   modport source (output valid, mode, address, base_ptr, alloc_size, call_site,
                   probe_index, input ready);
   modport sink   (input valid, mode, address, base_ptr, alloc_size, call_site,
                   probe_index, output ready);
endinterface

interface tpbc_rsp_if;
   import tpbc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ADDR_W-1:0]    result_address;
   status_type           status;
   logic [ETAG_W-1:0]    entry_tag;
   logic [EBASE_W-1:0]   entry_base;
   logic [SIZE_W-1:0]    entry_size;
   logic [SITE_W-1:0]    entry_site;
   logic                 leaked;

   modport source (output valid, result_address, status, entry_tag, entry_base,
                   entry_size, entry_site, leaked, input ready);
   modport sink   (input valid, result_address, status, entry_tag, entry_base,
                   entry_size, entry_site, leaked, output ready);
endinterface

// ===== src/tagged_pointer_bounds_checker.sv =====
// Tagged-pointer bounds checker. Each transaction on req_chan is an allocate, a free, an
// access check or a leak probe, and produces exactly one transaction on rsp_chan. Block
// records (base, size, call site, freed flag) live in one synchronous table memory indexed
// by the pointer tag; tags are handed out in order from 1, so an entry counts as in use
// exactly when it is nonzero and lies below the next tag, and the table needs no clearing
// after reset. A transaction goes through accept and table read, bound preparation (end
// address and header floor), then evaluation with write-back into the table and the
// result register. The result register lets the next transaction be accepted while a
// result waits; if rsp_chan stalls, evaluation waits until the result register frees up.
// Configuration (csr_*) may only be written while no transaction is in flight.
module tagged_pointer_bounds_checker #(
   parameter int TAG_SHIFT   = 52,
   parameter int TABLE_DEPTH = 4096,
   parameter int ENTRY_LIMIT = 4080
) (
   input  logic                             clock,
   input  logic                             reset,
   tpbc_req_if.sink                         req_chan,
   tpbc_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  tpbc_pkg::csr_index_type          csr_index,
   input  logic [tpbc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tpbc_pkg::*;

   localparam int     BASE_W  = TAG_SHIFT;
   localparam int     TW      = ADDR_W - TAG_SHIFT;
   localparam int     IDX_W   = $clog2(TABLE_DEPTH);
   localparam longint CAP     = longint'(1) << TW;
   localparam longint LIMIT_A = (ENTRY_LIMIT < TABLE_DEPTH) ? ENTRY_LIMIT : TABLE_DEPTH;
   localparam longint LIMIT   = (CAP < LIMIT_A) ? CAP : LIMIT_A;
   localparam int     NT_W    = $clog2(LIMIT + 1);
   localparam int     END_W   = ((BASE_W > SIZE_W) ? BASE_W : SIZE_W) + 1;

   localparam logic [NT_W-1:0] NT_LIMIT = NT_W'(LIMIT);
   localparam logic [NT_W-1:0] NT_ONE   = NT_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EVAL = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Configuration and allocation counter
   logic [HW_W-1:0]  hw_ff;
   logic [MBS_W-1:0] mbs_ff;
   logic [NT_W-1:0]  next_tag_ff, next_tag_in;

   // Captured request
   mode_type           mode_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [ADDR_W-1:0]  bin_ff;
   logic [SIZE_W-1:0]  asize_ff;
   logic [SITE_W-1:0]  site_ff;
   logic [PROBE_W-1:0] probe_ff;

   // Bound preparation stage
   logic [END_W-1:0]   end_ff, end_in;
   logic [BASE_W-1:0]  lo_ff, lo_in;
   logic               tracked_ff, tracked_in;
   logic [SIZE_W-1:0]  amax_ff, amax_in;

   // Table
   tbl_ctrl_type       tbl_ctrl;
   logic [IDX_W-1:0]   rd_idx, wr_idx;
   logic [BASE_W-1:0]  wr_base, rd_base;
   logic [SIZE_W-1:0]  wr_size, rd_size;
   logic [SITE_W-1:0]  wr_site, rd_site;
   logic               wr_freed, rd_freed;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   status_type         status_ff, status_in;
   logic [ETAG_W-1:0]  etag_ff, etag_in;
   logic [EBASE_W-1:0] ebase_ff, ebase_in;
   logic [SIZE_W-1:0]  esize_ff, esize_in;
   logic [SITE_W-1:0]  esite_ff, esite_in;
   logic               leaked_ff, leaked_in;

   logic               accept, fire;
   logic [ADDR_W-1:0]  req_key, key;
   logic [BASE_W-1:0]  stripped;
   logic [TW-1:0]      tag, btag;
   logic               full, in_body, in_hdr, alloc_ok;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign fire           = (state_ff == ST_EVAL) && (!rsp_valid_ff || rsp_chan.ready);

   // Table read index: probe entry or the pointer tag
   assign req_key = (req_chan.mode == MODE_PROBE) ? ADDR_W'(req_chan.probe_index)
                                                  : (req_chan.address >> TAG_SHIFT);
   assign rd_idx  = IDX_W'(req_key);

   assign stripped = addr_ff[BASE_W-1:0];
   assign tag      = addr_ff[ADDR_W-1:TAG_SHIFT];
   assign btag     = bin_ff[ADDR_W-1:TAG_SHIFT];
   assign key      = (mode_ff == MODE_PROBE) ? ADDR_W'(probe_ff) : ADDR_W'(tag);
   assign full     = (next_tag_ff >= NT_LIMIT);
   assign alloc_ok = (stripped != '0) && !full;

   // Bound preparation
   assign tracked_in = (key != '0) && (key < ADDR_W'(next_tag_ff));
   assign end_in     = END_W'(rd_base) + END_W'(rd_size);
   assign lo_in      = (rd_base >= BASE_W'(hw_ff)) ? rd_base - BASE_W'(hw_ff) : '0;
   assign amax_in    = (asize_ff > SIZE_W'(mbs_ff)) ? asize_ff : SIZE_W'(mbs_ff);

   // Range compares
   assign in_body = (END_W'(stripped) >= END_W'(rd_base)) && (END_W'(stripped) < end_ff);
   assign in_hdr  = (stripped >= lo_ff) && (END_W'(stripped) < end_ff);

   // Table write-back: new record on allocate, freed flag on free
   always_comb begin
      tbl_ctrl.rd_en = accept;
      tbl_ctrl.wr_en = 1'b0;
      if (fire) begin
         tbl_ctrl.wr_en = ((mode_ff == MODE_ALLOC) && alloc_ok) ||
                          ((mode_ff == MODE_FREE) && tracked_ff);
      end
      if (mode_ff == MODE_ALLOC) begin
         wr_idx   = IDX_W'(next_tag_ff);
         wr_base  = stripped;
         wr_size  = amax_ff;
         wr_site  = site_ff;
         wr_freed = 1'b0;
      end else begin
         wr_idx   = IDX_W'(tag);
         wr_base  = rd_base;
         wr_size  = rd_size;
         wr_site  = rd_site;
         wr_freed = 1'b1;
      end
   end

   tpbc_table #(
      .DEPTH  (TABLE_DEPTH),
      .BASE_W (BASE_W)
   ) u_table (
      .clock    (clock),
      .ctrl     (tbl_ctrl),
      .rd_idx   (rd_idx),
      .wr_idx   (wr_idx),
      .wr_base  (wr_base),
      .wr_size  (wr_size),
      .wr_site  (wr_site),
      .wr_freed (wr_freed),
      .rd_base  (rd_base),
      .rd_size  (rd_size),
      .rd_site  (rd_site),
      .rd_freed (rd_freed)
   );

   // Result evaluation
   always_comb begin
      res_addr_in = '0;
      status_in   = STATUS_OK;
      etag_in     = '0;
      ebase_in    = '0;
      esize_in    = '0;
      esite_in    = '0;
      leaked_in   = 1'b0;
      next_tag_in = next_tag_ff;
      unique case (mode_ff)
         MODE_ALLOC: begin
            if (stripped == '0) begin
               status_in = STATUS_UNTRACKED;
            end else if (full) begin
               res_addr_in = ADDR_W'(stripped);
               status_in   = STATUS_TABLE_FULL;
            end else begin
               res_addr_in = ADDR_W'(stripped) | (ADDR_W'(next_tag_ff) << TAG_SHIFT);
               etag_in     = ETAG_W'(next_tag_ff);
               ebase_in    = EBASE_W'(stripped);
               esize_in    = amax_ff;
               esite_in    = site_ff;
               next_tag_in = next_tag_ff + NT_ONE;
            end
         end
         MODE_FREE: begin
            res_addr_in = ADDR_W'(stripped);
            if (!tracked_ff) begin
               status_in = STATUS_UNTRACKED;
            end else begin
               status_in = rd_freed ? STATUS_DOUBLE_FREE : STATUS_OK;
               etag_in   = ETAG_W'(tag);
               ebase_in  = EBASE_W'(rd_base);
               esize_in  = rd_size;
               esite_in  = rd_site;
            end
         end
         MODE_ACCESS: begin
            priority if (bin_ff[ADDR_W-1:STACK_LSB] == STACK_MARK) begin
               res_addr_in = bin_ff;
            end else if (btag != tag) begin
               res_addr_in = bin_ff;
               status_in   = STATUS_TAG_MISMATCH;
            end else if (!tracked_ff) begin
               res_addr_in = bin_ff;
               status_in   = STATUS_UNTRACKED;
            end else begin
               res_addr_in = ADDR_W'(bin_ff[BASE_W-1:0]);
               etag_in     = ETAG_W'(tag);
               ebase_in    = EBASE_W'(rd_base);
               esize_in    = rd_size;
               esite_in    = rd_site;
               priority if (rd_freed) begin
                  status_in = STATUS_USE_AFTER;
               end else if (in_body) begin
                  status_in = STATUS_OK;
               end else if (in_hdr) begin
                  status_in = STATUS_HEADER;
               end else begin
                  status_in = STATUS_OUT_OF_BOUND;
               end
            end
         end
         MODE_PROBE: begin
            if (!tracked_ff) begin
               status_in = STATUS_UNTRACKED;
            end else begin
               etag_in   = ETAG_W'(probe_ff);
               ebase_in  = EBASE_W'(rd_base);
               esize_in  = rd_size;
               esite_in  = rd_site;
               leaked_in = !rd_freed;
            end
         end
         default: begin
            status_in = STATUS_UNTRACKED;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: if (fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         next_tag_ff  <= NT_ONE;
         hw_ff        <= HW_RESET;
         mbs_ff       <= MBS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            next_tag_ff <= next_tag_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_HEADER_WINDOW:  hw_ff  <= csr_wdata[HW_W-1:0];
               CSR_MIN_BLOCK_SIZE: mbs_ff <= csr_wdata[MBS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_chan.mode;
         addr_ff  <= req_chan.address;
         bin_ff   <= req_chan.base_ptr;
         asize_ff <= req_chan.alloc_size;
         site_ff  <= req_chan.call_site;
         probe_ff <= req_chan.probe_index;
      end
      if (state_ff == ST_READ) begin
         end_ff     <= end_in;
         lo_ff      <= lo_in;
         tracked_ff <= tracked_in;
         amax_ff    <= amax_in;
      end
      if (fire) begin
         res_addr_ff <= res_addr_in;
         status_ff   <= status_in;
         etag_ff     <= etag_in;
         ebase_ff    <= ebase_in;
         esize_ff    <= esize_in;
         esite_ff    <= esite_in;
         leaked_ff   <= leaked_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_address = res_addr_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.entry_tag      = etag_ff;
   assign rsp_chan.entry_base     = ebase_ff;
   assign rsp_chan.entry_size     = esize_ff;
   assign rsp_chan.entry_site     = esite_ff;
   assign rsp_chan.leaked         = leaked_ff;

endmodule

// ===== src/tpbc_table.sv =====
module tpbc_table #(
   parameter int DEPTH  = 4096,
   parameter int BASE_W = 52
) (
   input  logic                         clock,
   input  tpbc_pkg::tbl_ctrl_type       ctrl,
   input  logic [$clog2(DEPTH)-1:0]     rd_idx,
   input  logic [$clog2(DEPTH)-1:0]     wr_idx,
   input  logic [BASE_W-1:0]            wr_base,
   input  logic [tpbc_pkg::SIZE_W-1:0]  wr_size,
   input  logic [tpbc_pkg::SITE_W-1:0]  wr_site,
   input  logic                         wr_freed,
   output logic [BASE_W-1:0]            rd_base,
   output logic [tpbc_pkg::SIZE_W-1:0]  rd_size,
   output logic [tpbc_pkg::SITE_W-1:0]  rd_site,
   output logic                         rd_freed
);
   import tpbc_pkg::*;

   localparam int REC_W = BASE_W + SIZE_W + SITE_W + 1;

   logic [REC_W-1:0] mem [DEPTH];
   logic [REC_W-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_idx] <= {wr_base, wr_size, wr_site, wr_freed};
      end
      if (ctrl.rd_en) begin
         rdata_ff <= mem[rd_idx];
      end
   end

   assign {rd_base, rd_size, rd_site, rd_freed} = rdata_ff;

endmodule
